// ===== hdl/wcp_pkg.sv =====
// ----------------------------------------------------------------------------
// wcp_pkg: shared types, constants and functions for the wall clip block
// Holds the field widths, the pipeline stage map, the register codes, the
// quarter sine table and the helper functions used by the datapath.
// ----------------------------------------------------------------------------
package wcp_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int ANGLE_STEPS   = 360;
  localparam int FOCAL         = 200;

  // Datapath widths.
  localparam int W_C   = 19;  // rotated x and depth
  localparam int W_Z   = 24;  // bottom and top heights
  localparam int W_DEN = 20;  // clip ratio divider operands
  localparam int W_RQ  = 16;  // clip ratio, Q0.16
  localparam int W_PX  = W_C + 1 + W_RQ + 1;
  localparam int W_PZ  = W_Z + 1 + W_RQ + 1;
  localparam int W_N   = 32;  // projection dividend, |v| * focal
  localparam int W_PD  = 18;  // projection divisor
  localparam int W_PQ  = 17;  // projection quotient bits kept
  localparam int W_ADDR = 5;

  // Divider layout.
  localparam int RD_STAGES = 4;
  localparam int RD_STEPS  = W_RQ / RD_STAGES;
  localparam int PD_STAGES = 5;
  localparam int PD_STEPS  = 4;

  // Pipeline stage map.
  localparam int ST_TR    = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_ROT   = 3;
  localparam int ST_Z     = 4;
  localparam int ST_SEL   = 5;
  localparam int ST_LMUL  = ST_SEL + RD_STAGES + 1;
  localparam int ST_LERP  = ST_LMUL + 1;
  localparam int ST_NUM   = ST_LERP + 1;
  localparam int ST_PD    = ST_NUM + 1;
  localparam int ST_OUT   = ST_PD + PD_STAGES;
  localparam int N_STAGES = ST_OUT;

  // Register codes (byte address divided by four).
  localparam logic [2:0] REG_CAM_X       = 3'd0;
  localparam logic [2:0] REG_CAM_Y       = 3'd1;
  localparam logic [2:0] REG_CAM_Z       = 3'd2;
  localparam logic [2:0] REG_CAM_HEADING = 3'd3;
  localparam logic [2:0] REG_CAM_PITCH   = 3'd4;

  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [W_C-1:0] x;
    logic signed [W_C-1:0] d;
    logic signed [W_Z-1:0] zb;
    logic signed [W_Z-1:0] zt;
  } pts_t;

  typedef struct packed {
    pts_t              near;
    pts_t              far;
    logic              clip;
    logic              sel1;
    logic              vis;
    logic [W_DEN-1:0]  rem;
    logic [W_DEN-1:0]  den;
    logic [W_RQ-1:0]   q;
  } rdiv_t;

  typedef struct packed {
    logic [W_PD-1:0] rem;
    logic [W_PQ-1:0] low;
    logic [W_PQ-1:0] q;
    logic [W_PD-1:0] den;
    logic            ovf;
    logic            neg;
  } pdiv_t;

  localparam logic [14:0] QSINE [0:90] = '{
    15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997,
    15'd2280, 15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964,
    15'd4240, 15'd4516, 15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872,
    15'd6138, 15'd6402, 15'd6664, 15'd6924, 15'd7182, 15'd7438, 15'd7692,
    15'd7943, 15'd8192, 15'd8438, 15'd8682, 15'd8923, 15'd9162, 15'd9397,
    15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531, 15'd10749, 15'd10963,
    15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189,
    15'd14330, 15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968,
    15'd15082, 15'd15191, 15'd15296, 15'd15396, 15'd15491, 15'd15582,
    15'd15668, 15'd15749, 15'd15826, 15'd15897, 15'd15964, 15'd16026,
    15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of a whole degree in 0..359, Q1.14.
  function automatic logic signed [15:0] sine_deg(input logic [8:0] d);
    logic [6:0] idx;
    logic neg;
    logic signed [15:0] val;
    neg = 1'b0;
    if (d <= 9'd90) begin
      idx = d[6:0];
    end else if (d <= 9'd180) begin
      idx = 7'(9'd180 - d);
    end else if (d <= 9'd270) begin
      idx = 7'(d - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - d);
      neg = 1'b1;
    end
    val = signed'({1'b0, QSINE[idx]});
    return neg ? -val : val;
  endfunction

  // Cosine and sine for a heading; codes past the last degree wrap once.
  function automatic trig_t trig_lookup(input logic [8:0] heading);
    logic [8:0] h;
    logic [9:0] hc;
    trig_t t;
    h = (heading >= 9'(ANGLE_STEPS)) ? 9'(heading - 9'(ANGLE_STEPS)) : heading;
    hc = {1'b0, h} + 10'd90;
    if (hc >= 10'(ANGLE_STEPS)) begin
      hc = hc - 10'(ANGLE_STEPS);
    end
    t.c = sine_deg(hc[8:0]);
    t.s = sine_deg(h);
    return t;
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [47:0] trunc_sh(input logic signed [47:0] v,
                                                  input int sh);
    logic signed [47:0] bias;
    bias = v[47] ? ((48'sd1 <<< sh) - 48'sd1) : 48'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// ===== hdl/wcp_pdiv.sv =====
// ----------------------------------------------------------------------------
// wcp_pdiv: pipelined unsigned divider for the perspective projection
// Restoring division of |v| * focal by depth, up to four quotient bits per
// stage, with an overflow flag when the quotient does not fit the kept bits.
// ----------------------------------------------------------------------------
module wcp_pdiv (
  input  logic                             clk,
  input  logic [wcp_pkg::PD_STAGES-1:0]    adv,
  input  logic [wcp_pkg::W_N-1:0]          num,
  input  logic [wcp_pkg::W_PD-1:0]         den,
  input  logic                             neg,
  output logic [wcp_pkg::W_PQ-1:0]         quo,
  output logic                             ovf,
  output logic                             neg_out
);

  wcp_pkg::pdiv_t st_r  [0:wcp_pkg::PD_STAGES-1];
  wcp_pkg::pdiv_t st_nxt[0:wcp_pkg::PD_STAGES-1];
  wcp_pkg::pdiv_t init;

  always_comb begin
    init.rem = wcp_pkg::W_PD'(num[wcp_pkg::W_N-1:wcp_pkg::W_PQ]);
    init.low = num[wcp_pkg::W_PQ-1:0];
    init.q   = '0;
    init.den = den;
    init.ovf = (wcp_pkg::W_PD'(num[wcp_pkg::W_N-1:wcp_pkg::W_PQ]) >= den);
    init.neg = neg;
  end

  for (genvar s = 0; s < wcp_pkg::PD_STAGES; s++) begin : g_stage
    always_comb begin
      wcp_pkg::pdiv_t c;
      logic [wcp_pkg::W_PD:0] t;
      c = (s == 0) ? init : st_r[(s == 0) ? 0 : s - 1];
      t = '0;
      for (int j = 0; j < wcp_pkg::PD_STEPS; j++) begin
        if (s * wcp_pkg::PD_STEPS + j < wcp_pkg::W_PQ) begin
          t = {c.rem, c.low[wcp_pkg::W_PQ-1]};
          c.low = c.low << 1;
          if (t >= {1'b0, c.den}) begin
            c.rem = wcp_pkg::W_PD'(t - {1'b0, c.den});
            c.q   = {c.q[wcp_pkg::W_PQ-2:0], 1'b1};
          end else begin
            c.rem = t[wcp_pkg::W_PD-1:0];
            c.q   = {c.q[wcp_pkg::W_PQ-2:0], 1'b0};
          end
        end
      end
      st_nxt[s] = c;
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign quo     = st_r[wcp_pkg::PD_STAGES-1].q;
  assign ovf     = st_r[wcp_pkg::PD_STAGES-1].ovf;
  assign neg_out = st_r[wcp_pkg::PD_STAGES-1].neg;

endmodule

// ===== hdl/wall_clip_and_project.sv =====
// ----------------------------------------------------------------------------
// wall_clip_and_project: near-plane clip and perspective projection of walls
// Translates and rotates a wall into camera space, applies the pitch term,
// clips an endpoint that lies behind the near plane and projects both
// endpoints to screen x and to bottom and top y.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake               | Word
//  ---------+-----------+-------------------------+-------------------------------
//  in_*     | input     | in_valid / in_stall     | wall endpoints, floor, height
//  out_*    | output    | out_valid / out_stall   | visible flag, six screen values
//  APB      | input     | psel/penable/pwrite     | camera position, heading, pitch
//
// One word enters per clock while in_stall is low, and each result passes
// through the 18 register stages: five for the transform, four for the clip
// ratio divider, three for the interpolation and dividend set-up, five for
// the projection dividers and one output register. Each stage holds a valid
// bit and loads whenever it is empty or the stage after it moves, so a stall
// at the output backs up stage by stage and bubbles are squeezed out. Reset
// clears the valid bits and the camera registers; there is no warm-up, the
// trig table is constant logic.
//
module wall_clip_and_project (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_wall_ax,
  input  logic signed [15:0]           in_wall_ay,
  input  logic signed [15:0]           in_wall_bx,
  input  logic signed [15:0]           in_wall_by,
  input  logic signed [15:0]           in_floor_level,
  input  logic [14:0]                  in_sector_height,
  input  logic                         in_back_face,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_visible,
  output logic signed [15:0]           out_screen_left_x,
  output logic signed [15:0]           out_screen_right_x,
  output logic signed [15:0]           out_bottom_left_y,
  output logic signed [15:0]           out_bottom_right_y,
  output logic signed [15:0]           out_top_left_y,
  output logic signed [15:0]           out_top_right_y,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wcp_pkg::W_ADDR-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NS = wcp_pkg::N_STAGES;
  localparam int WC = wcp_pkg::W_C;
  localparam int WZ = wcp_pkg::W_Z;

  // --------------------------------------------------------------------------
  // Camera regs: user must make writes only while the pipeline is idle, unchecked.
  // --------------------------------------------------------------------------
  logic signed [15:0] cam_x_r, cam_y_r, cam_z_r;
  logic [8:0]         cam_heading_r;
  logic signed [7:0]  cam_pitch_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[wcp_pkg::W_ADDR-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r       <= '0;
      cam_y_r       <= '0;
      cam_z_r       <= '0;
      cam_heading_r <= '0;
      cam_pitch_r   <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        wcp_pkg::REG_CAM_X:       cam_x_r       <= pwdata[15:0];
        wcp_pkg::REG_CAM_Y:       cam_y_r       <= pwdata[15:0];
        wcp_pkg::REG_CAM_Z:       cam_z_r       <= pwdata[15:0];
        wcp_pkg::REG_CAM_HEADING: cam_heading_r <= pwdata[8:0];
        wcp_pkg::REG_CAM_PITCH:   cam_pitch_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      wcp_pkg::REG_CAM_X:       prdata = {16'b0, cam_x_r};
      wcp_pkg::REG_CAM_Y:       prdata = {16'b0, cam_y_r};
      wcp_pkg::REG_CAM_Z:       prdata = {16'b0, cam_z_r};
      wcp_pkg::REG_CAM_HEADING: prdata = {23'b0, cam_heading_r};
      wcp_pkg::REG_CAM_PITCH:   prdata = {24'b0, cam_pitch_r};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage flow control. A stage loads when it is empty or its successor
  // loads; the output register frees up when the consumer is not stalling.
  // --------------------------------------------------------------------------
  logic [NS:1]   vld_r;
  logic [NS+1:1] rdy;

  always_comb begin
    rdy[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= (k == 1) ? in_valid : vld_r[(k == 1) ? 1 : k - 1];
        end
      end
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = vld_r[NS];

  // --------------------------------------------------------------------------
  // Stage 1: translate by the camera and apply the back-face swap.
  // --------------------------------------------------------------------------
  logic signed [16:0] s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r, s1_base_r;
  logic [14:0]        s1_ht_r;
  logic signed [16:0] ta_x, ta_y, tb_x, tb_y;

  always_comb begin
    ta_x = signed'({in_wall_ax[15], in_wall_ax}) - signed'({cam_x_r[15], cam_x_r});
    ta_y = signed'({in_wall_ay[15], in_wall_ay}) - signed'({cam_y_r[15], cam_y_r});
    tb_x = signed'({in_wall_bx[15], in_wall_bx}) - signed'({cam_x_r[15], cam_x_r});
    tb_y = signed'({in_wall_by[15], in_wall_by}) - signed'({cam_y_r[15], cam_y_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_TR]) begin
      s1_x0_r   <= in_back_face ? tb_x : ta_x;
      s1_y0_r   <= in_back_face ? tb_y : ta_y;
      s1_x1_r   <= in_back_face ? ta_x : tb_x;
      s1_y1_r   <= in_back_face ? ta_y : tb_y;
      s1_base_r <= signed'({in_floor_level[15], in_floor_level})
                   - signed'({cam_z_r[15], cam_z_r});
      s1_ht_r   <= in_sector_height;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the eight rotation products.
  // --------------------------------------------------------------------------
  wcp_pkg::trig_t     trig;
  logic signed [32:0] s2_x0c_r, s2_y0s_r, s2_y0c_r, s2_x0s_r;
  logic signed [32:0] s2_x1c_r, s2_y1s_r, s2_y1c_r, s2_x1s_r;
  logic signed [16:0] s2_base_r;
  logic [14:0]        s2_ht_r;

  assign trig = wcp_pkg::trig_lookup(cam_heading_r);

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_MUL]) begin
      s2_x0c_r  <= 33'(s1_x0_r) * 33'(trig.c);
      s2_y0s_r  <= 33'(s1_y0_r) * 33'(trig.s);
      s2_y0c_r  <= 33'(s1_y0_r) * 33'(trig.c);
      s2_x0s_r  <= 33'(s1_x0_r) * 33'(trig.s);
      s2_x1c_r  <= 33'(s1_x1_r) * 33'(trig.c);
      s2_y1s_r  <= 33'(s1_y1_r) * 33'(trig.s);
      s2_y1c_r  <= 33'(s1_y1_r) * 33'(trig.c);
      s2_x1s_r  <= 33'(s1_x1_r) * 33'(trig.s);
      s2_base_r <= s1_base_r;
      s2_ht_r   <= s1_ht_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum the products and drop the Q1.14 scale toward zero.
  // --------------------------------------------------------------------------
  logic signed [WC-1:0] s3_wx0_r, s3_wx1_r, s3_d0_r, s3_d1_r;
  logic signed [16:0]   s3_base_r;
  logic [14:0]          s3_ht_r;
  logic signed [33:0]   r_wx0, r_wx1, r_d0, r_d1;

  always_comb begin
    r_wx0 = 34'(s2_x0c_r) - 34'(s2_y0s_r);
    r_wx1 = 34'(s2_x1c_r) - 34'(s2_y1s_r);
    r_d0  = 34'(s2_y0c_r) + 34'(s2_x0s_r);
    r_d1  = 34'(s2_y1c_r) + 34'(s2_x1s_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_ROT]) begin
      s3_wx0_r  <= WC'(wcp_pkg::trunc_sh(48'(r_wx0), 14));
      s3_wx1_r  <= WC'(wcp_pkg::trunc_sh(48'(r_wx1), 14));
      s3_d0_r   <= WC'(wcp_pkg::trunc_sh(48'(r_d0), 14));
      s3_d1_r   <= WC'(wcp_pkg::trunc_sh(48'(r_d1), 14));
      s3_base_r <= s2_base_r;
      s3_ht_r   <= s2_ht_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: height sum 32 * base + pitch * depth, still scaled by 32.
  // --------------------------------------------------------------------------
  logic signed [27:0]   s4_zs0_r, s4_zs1_r;
  logic signed [WC-1:0] s4_wx0_r, s4_wx1_r, s4_d0_r, s4_d1_r;
  logic [14:0]          s4_ht_r;
  logic signed [27:0]   base32;

  assign base32 = 28'(s3_base_r) <<< 5;

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_Z]) begin
      s4_zs0_r <= base32 + 28'(cam_pitch_r) * 28'(s3_d0_r);
      s4_zs1_r <= base32 + 28'(cam_pitch_r) * 28'(s3_d1_r);
      s4_wx0_r <= s3_wx0_r;
      s4_wx1_r <= s3_wx1_r;
      s4_d0_r  <= s3_d0_r;
      s4_d1_r  <= s3_d1_r;
      s4_ht_r  <= s3_ht_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: finish the heights, classify the wall against the near plane
  // and pick the near and far endpoints. The near depth is the negative
  // numerator of the clip ratio and the depth span is its denominator.
  // --------------------------------------------------------------------------
  wcp_pkg::rdiv_t rd_r[0:wcp_pkg::RD_STAGES];
  wcp_pkg::rdiv_t sel_nxt;

  always_comb begin
    wcp_pkg::pts_t p0, p1;
    logic lt0, lt1;
    logic signed [wcp_pkg::W_DEN-1:0] nd_e, fd_e;
    p0.x  = s4_wx0_r;
    p0.d  = s4_d0_r;
    p0.zb = WZ'(wcp_pkg::trunc_sh(48'(s4_zs0_r), 5));
    p0.zt = p0.zb + signed'({{(WZ - 15){1'b0}}, s4_ht_r});
    p1.x  = s4_wx1_r;
    p1.d  = s4_d1_r;
    p1.zb = WZ'(wcp_pkg::trunc_sh(48'(s4_zs1_r), 5));
    p1.zt = p1.zb + signed'({{(WZ - 15){1'b0}}, s4_ht_r});
    lt0 = (s4_d0_r < WC'(1));
    lt1 = (s4_d1_r < WC'(1));
    sel_nxt.vis  = !(lt0 && lt1);
    sel_nxt.clip = sel_nxt.vis && (lt0 || lt1);
    // Endpoint 1 is the one to move only when endpoint 0 is in front.
    sel_nxt.sel1 = !lt0;
    sel_nxt.near = sel_nxt.sel1 ? p1 : p0;
    sel_nxt.far  = sel_nxt.sel1 ? p0 : p1;
    nd_e = wcp_pkg::W_DEN'(sel_nxt.near.d);
    fd_e = wcp_pkg::W_DEN'(sel_nxt.far.d);
    sel_nxt.rem = sel_nxt.clip ? wcp_pkg::W_DEN'(-nd_e) : '0;
    sel_nxt.den = sel_nxt.clip ? wcp_pkg::W_DEN'(fd_e - nd_e) : wcp_pkg::W_DEN'(1);
    sel_nxt.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_SEL]) begin
      rd_r[0] <= sel_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6 to 9: clip ratio, floor(num * 2^16 / den). The numerator is
  // always below the denominator, so sixteen restoring steps give the ratio.
  // --------------------------------------------------------------------------
  for (genvar s = 1; s <= wcp_pkg::RD_STAGES; s++) begin : g_rdiv
    wcp_pkg::rdiv_t rd_nxt;

    always_comb begin
      logic [wcp_pkg::W_DEN:0] t;
      rd_nxt = rd_r[s-1];
      for (int j = 0; j < wcp_pkg::RD_STEPS; j++) begin
        t = {rd_nxt.rem, 1'b0};
        if (t >= {1'b0, rd_nxt.den}) begin
          rd_nxt.rem = wcp_pkg::W_DEN'(t - {1'b0, rd_nxt.den});
          rd_nxt.q   = {rd_nxt.q[wcp_pkg::W_RQ-2:0], 1'b1};
        end else begin
          rd_nxt.rem = t[wcp_pkg::W_DEN-1:0];
          rd_nxt.q   = {rd_nxt.q[wcp_pkg::W_RQ-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[wcp_pkg::ST_SEL + s]) begin
        rd_r[s] <= rd_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: ratio times the span of each coordinate. Bottom and top share
  // one span since the sector height is the same at both ends.
  // --------------------------------------------------------------------------
  wcp_pkg::rdiv_t                     rdo;
  wcp_pkg::pts_t                      s10_near_r, s10_far_r;
  logic                               s10_clip_r, s10_sel1_r, s10_vis_r;
  logic signed [wcp_pkg::W_PX-1:0]    s10_px_r, s10_pd_r;
  logic signed [wcp_pkg::W_PZ-1:0]    s10_pz_r;
  logic signed [WC:0]                 dx, dd;
  logic signed [WZ:0]                 dz;
  logic signed [wcp_pkg::W_RQ:0]      ratio;

  assign rdo   = rd_r[wcp_pkg::RD_STAGES];
  assign ratio = signed'({1'b0, rdo.q});
  assign dx    = (WC + 1)'(rdo.far.x) - (WC + 1)'(rdo.near.x);
  assign dd    = (WC + 1)'(rdo.far.d) - (WC + 1)'(rdo.near.d);
  assign dz    = (WZ + 1)'(rdo.far.zb) - (WZ + 1)'(rdo.near.zb);

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_LMUL]) begin
      s10_near_r <= rdo.near;
      s10_far_r  <= rdo.far;
      s10_clip_r <= rdo.clip;
      s10_sel1_r <= rdo.sel1;
      s10_vis_r  <= rdo.vis;
      s10_px_r   <= wcp_pkg::W_PX'(ratio) * wcp_pkg::W_PX'(dx);
      s10_pd_r   <= wcp_pkg::W_PX'(ratio) * wcp_pkg::W_PX'(dd);
      s10_pz_r   <= wcp_pkg::W_PZ'(ratio) * wcp_pkg::W_PZ'(dz);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: finish the interpolation, force depths up to one, and put the
  // endpoints back in their original order.
  // --------------------------------------------------------------------------
  logic signed [WZ-1:0]          s11_v_r[0:5];
  logic [wcp_pkg::W_PD-1:0]      s11_d_r[0:1];
  logic                          s11_vis_r;
  wcp_pkg::pts_t                 e0, e1;

  always_comb begin
    wcp_pkg::pts_t n;
    wcp_pkg::pts_t f;
    n = s10_near_r;
    f = s10_far_r;
    if (s10_clip_r) begin
      n.x  = WC'(wcp_pkg::trunc_sh(48'((48'(s10_near_r.x) <<< 16) + 48'(s10_px_r)), 16));
      n.d  = WC'(wcp_pkg::trunc_sh(48'((48'(s10_near_r.d) <<< 16) + 48'(s10_pd_r)), 16));
      n.zb = WZ'(wcp_pkg::trunc_sh(48'((48'(s10_near_r.zb) <<< 16) + 48'(s10_pz_r)), 16));
      n.zt = WZ'(wcp_pkg::trunc_sh(48'((48'(s10_near_r.zt) <<< 16) + 48'(s10_pz_r)), 16));
    end
    if (n.d < WC'(1)) begin
      n.d = WC'(1);
    end
    if (f.d < WC'(1)) begin
      f.d = WC'(1);
    end
    e0 = s10_sel1_r ? f : n;
    e1 = s10_sel1_r ? n : f;
  end

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_LERP]) begin
      s11_v_r[0] <= WZ'(e0.x);
      s11_v_r[1] <= WZ'(e1.x);
      s11_v_r[2] <= e0.zb;
      s11_v_r[3] <= e1.zb;
      s11_v_r[4] <= e0.zt;
      s11_v_r[5] <= e1.zt;
      s11_d_r[0] <= e0.d[wcp_pkg::W_PD-1:0];
      s11_d_r[1] <= e1.d[wcp_pkg::W_PD-1:0];
      s11_vis_r  <= s10_vis_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: dividends |v| * focal and their signs.
  // Stages 13 to 17: six projection dividers, one lane per output value.
  // --------------------------------------------------------------------------
  logic [wcp_pkg::W_N-1:0]   s12_n_r[0:5];
  logic                      s12_neg_r[0:5];
  logic [wcp_pkg::W_PD-1:0]  s12_d_r[0:1];
  logic                      s12_vis_r;
  logic                      vis_p_r[0:wcp_pkg::PD_STAGES-1];
  logic [wcp_pkg::W_PQ-1:0]  pq[0:5];
  logic                      povf[0:5];
  logic                      pneg[0:5];
  logic signed [15:0]        res_r[0:5];
  logic                      out_vis_r;

  for (genvar i = 0; i < 6; i++) begin : g_lane
    logic [WZ-1:0] mag;
    logic signed [18:0] sq, sum, off;

    assign mag = s11_v_r[i][WZ-1] ? WZ'(-s11_v_r[i]) : WZ'(s11_v_r[i]);

    always_ff @(posedge clk) begin
      if (rdy[wcp_pkg::ST_NUM]) begin
        s12_n_r[i]   <= wcp_pkg::W_N'(mag) * wcp_pkg::W_N'(wcp_pkg::FOCAL);
        s12_neg_r[i] <= s11_v_r[i][WZ-1];
      end
    end

    wcp_pdiv u_pdiv (
      .clk     (clk),
      .adv     (rdy[wcp_pkg::ST_PD + wcp_pkg::PD_STAGES - 1:wcp_pkg::ST_PD]),
      .num     (s12_n_r[i]),
      .den     (s12_d_r[i % 2]),
      .neg     (s12_neg_r[i]),
      .quo     (pq[i]),
      .ovf     (povf[i]),
      .neg_out (pneg[i])
    );

    // Screen x lanes come first and center on the width, the rest on height.
    assign off = (i < 2) ? 19'(wcp_pkg::SCREEN_WIDTH / 2)
                         : 19'(wcp_pkg::SCREEN_HEIGHT / 2);
    assign sq  = pneg[i] ? -signed'({2'b0, pq[i]}) : signed'({2'b0, pq[i]});
    assign sum = sq + off;

    always_ff @(posedge clk) begin
      if (rdy[wcp_pkg::ST_OUT]) begin
        if (!vis_p_r[wcp_pkg::PD_STAGES-1]) begin
          res_r[i] <= '0;
        end else if (povf[i]) begin
          res_r[i] <= pneg[i] ? 16'sh8000 : 16'sh7fff;
        end else if (sum > 19'sd32767) begin
          res_r[i] <= 16'sh7fff;
        end else if (sum < -19'sd32768) begin
          res_r[i] <= 16'sh8000;
        end else begin
          res_r[i] <= sum[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_NUM]) begin
      s12_d_r[0] <= s11_d_r[0];
      s12_d_r[1] <= s11_d_r[1];
      s12_vis_r  <= s11_vis_r;
    end
  end

  // The visible flag rides alongside the dividers.
  for (genvar s = 0; s < wcp_pkg::PD_STAGES; s++) begin : g_vis
    always_ff @(posedge clk) begin
      if (rdy[wcp_pkg::ST_PD + s]) begin
        vis_p_r[s] <= (s == 0) ? s12_vis_r : vis_p_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[wcp_pkg::ST_OUT]) begin
      out_vis_r <= vis_p_r[wcp_pkg::PD_STAGES-1];
    end
  end

  assign out_visible        = out_vis_r;
  assign out_screen_left_x  = res_r[0];
  assign out_screen_right_x = res_r[1];
  assign out_bottom_left_y  = res_r[2];
  assign out_bottom_right_y = res_r[3];
  assign out_top_left_y     = res_r[4];
  assign out_top_right_y    = res_r[5];

endmodule
